FILE: hdl/trle_pkg.sv
// Shared types and constants for the triple redundant run-length encoder.
// No dependencies; imported by the tracker, the emitter and the top level.
`default_nettype none

package trle_pkg;

    // Default number of copies of each encoded byte
    localparam int COPIES_DEFAULT = 3;

    // Digit range bounds and code offsets
    localparam logic [7:0] DIGIT_LO      = 8'd47;
    localparam logic [7:0] DIGIT_HI      = 8'd58;
    localparam logic [7:0] DIGIT_SINGLE  = 8'd20;
    localparam logic [7:0] DIGIT_MULTI   = 8'd10;
    localparam logic [7:0] LETTER_MULTI  = 8'd32;
    localparam logic [7:0] LEN_WITH_COPY = 8'd3;
    localparam logic [7:0] LEN_MAX       = 8'd255;
    localparam logic [7:0] END_MARK      = 8'd0;

    // One finished run, ready to be written out
    typedef struct packed {
        logic [7:0] code_byte;
        logic [7:0] run_len;
        logic       has_len;
    } run_desc_t;

endpackage

`default_nettype wire

FILE: hdl/triple_redundant_run_length_encoder_top.sv
// Top level of the triple redundant run-length encoder.
// Depends on trle_pkg, trle_tracker and trle_emitter.
//
//  channel | dir | ports                          | transfer when
//  s_      | in  | s_symbol_in                    | s_valid && s_ready
//  m_      | out | m_code_byte, m_last_of_run     | m_valid && m_ready
//
// An input byte is taken when s_valid and s_ready are high; a byte that closes a
// run yields COPIES or 2*COPIES result bytes, one per cycle from the emitter's
// output counter while m_ready holds high.
// A one-entry descriptor register lets the tracker take bytes while the emitter
// drains; s_ready drops only while that register is full and not being loaded out.
// Reset (aresetn, synchronous, active low) discards any open run and drops results.
`default_nettype none

module triple_redundant_run_length_encoder_top #(
    parameter int COPIES = trle_pkg::COPIES_DEFAULT
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_symbol_in,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_code_byte,
    output logic       m_last_of_run
);
    import trle_pkg::*;

    logic      desc_valid;
    logic      desc_ready;
    run_desc_t desc;

    trle_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_symbol_in (s_symbol_in),
        .desc_valid  (desc_valid),
        .desc_ready  (desc_ready),
        .desc        (desc)
    );

    trle_emitter #(
        .COPIES (COPIES)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .desc_valid    (desc_valid),
        .desc_ready    (desc_ready),
        .desc          (desc),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_byte   (m_code_byte),
        .m_last_of_run (m_last_of_run)
    );

`ifndef NO_ASSERTIONS
    // Input stalls only behind a pending descriptor
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> desc_valid)
        else $error("input stalled with no pending descriptor");

    // A pending descriptor is only held back while a result is being shown
    a_desc_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (desc_valid && !desc_ready) |-> m_valid)
        else $error("descriptor waiting while emitter idle");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

FILE: hdl/trle_tracker.sv
// Run tracker: follows the open run and encodes a finished run into a descriptor.
// Depends on trle_pkg; feeds trle_emitter through a one-entry descriptor register.
`default_nettype none

module trle_tracker (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [7:0]            s_symbol_in,
    output logic                  desc_valid,
    input  wire                   desc_ready,
    output trle_pkg::run_desc_t   desc
);
    import trle_pkg::*;

    logic [7:0] run_symbol_reg, run_symbol_next;
    logic [7:0] run_length_reg, run_length_next;
    logic       desc_valid_reg, desc_valid_next;
    run_desc_t  desc_reg, desc_next;

    logic       s_xfer;
    logic       emit;
    logic       digit;
    run_desc_t  enc;

    // Take a new byte while the descriptor slot is free or being drained
    assign s_ready = !desc_valid_reg || desc_ready;
    assign s_xfer  = s_valid && s_ready;

    // Encode the open run
    always_comb begin
        digit = (run_symbol_reg > DIGIT_LO) && (run_symbol_reg < DIGIT_HI);
        if (run_length_reg == 8'd1) begin
            enc.code_byte = digit ? run_symbol_reg - DIGIT_SINGLE : run_symbol_reg;
        end else begin
            enc.code_byte = digit ? run_symbol_reg - DIGIT_MULTI
                                  : run_symbol_reg + LETTER_MULTI;
        end
        enc.run_len = run_length_reg;
        enc.has_len = (run_length_reg >= LEN_WITH_COPY);
    end

    // A differing byte closes an open run
    assign emit = (run_length_reg != 8'd0) && (s_symbol_in != run_symbol_reg);

    // Advance run state and descriptor slot
    always_comb begin
        run_symbol_next = run_symbol_reg;
        run_length_next = run_length_reg;
        desc_valid_next = desc_valid_reg && !desc_ready;
        desc_next       = desc_reg;
        if (s_xfer) begin
            if (run_length_reg == 8'd0) begin
                if (s_symbol_in != END_MARK) begin
                    run_symbol_next = s_symbol_in;
                    run_length_next = 8'd1;
                end
            end else if (!emit) begin
                if (run_length_reg != LEN_MAX) begin
                    run_length_next = run_length_reg + 8'd1;
                end
            end else begin
                desc_valid_next = 1'b1;
                desc_next       = enc;
                run_symbol_next = s_symbol_in;
                run_length_next = (s_symbol_in == END_MARK) ? 8'd0 : 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_symbol_reg <= 8'd0;
            run_length_reg <= 8'd0;
            desc_valid_reg <= 1'b0;
        end else begin
            run_symbol_reg <= run_symbol_next;
            run_length_reg <= run_length_next;
            desc_valid_reg <= desc_valid_next;
        end
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

FILE: hdl/trle_emitter.sv
// Emitter: COPIES code bytes per descriptor, then COPIES length bytes if has_len.
// Depends on trle_pkg; driven by trle_tracker.
`default_nettype none

module trle_emitter #(
    parameter int COPIES = trle_pkg::COPIES_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   desc_valid,
    output logic                  desc_ready,
    input  trle_pkg::run_desc_t   desc,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [7:0]            m_code_byte,
    output logic                  m_last_of_run
);
    import trle_pkg::*;

    localparam int CNT_W = (COPIES > 1) ? $clog2(COPIES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COPIES - 1);

    logic             busy_reg, busy_next;
    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    run_desc_t        cur_reg, cur_next;

    logic m_xfer;
    logic copy_done;
    logic run_done;

    assign m_xfer    = busy_reg && m_ready;
    assign copy_done = (cnt_reg == CNT_LAST);
    assign run_done  = copy_done && (phase_reg || !cur_reg.has_len);

    // Load a new run when idle or on the final transfer of the current one
    assign desc_ready = !busy_reg || (m_xfer && run_done);

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        if (m_xfer) begin
            if (!copy_done) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end else if (!run_done) begin
                phase_next = 1'b1;
                cnt_next   = '0;
            end else begin
                busy_next = 1'b0;
            end
        end
        if (desc_valid && desc_ready) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = '0;
            cur_next   = desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
        cur_reg <= cur_next;
    end

    // Drive the result from held state
    assign m_valid       = busy_reg;
    assign m_code_byte   = phase_reg ? cur_reg.run_len : cur_reg.code_byte;
    assign m_last_of_run = run_done;

endmodule

`default_nettype wire

FILE: dv/tb_triple_redundant_run_length_encoder_top.sv
// Testbench for triple_redundant_run_length_encoder_top: directed and random byte streams.
// A scoreboard class predicts the encoded bytes and checks each one the block sends.
// Depends on trle_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module tb_triple_redundant_run_length_encoder_top;
    import trle_pkg::*;

    localparam int COPIES      = COPIES_DEFAULT;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int SOAK_ITEMS  = 250;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_item_t;

    // Predict encoded bytes from accepted symbols and compare them in order
    class run_code_checker;
        logic [7:0] open_sym;
        logic [7:0] open_len;
        code_item_t expected_codes[$];
        int         mismatches;

        function new();
            open_sym   = '0;
            open_len   = '0;
            mismatches = 0;
        endfunction

        function void push_copies(logic [7:0] code, bit closes);
            code_item_t item;
            for (int i = 0; i < COPIES; i++) begin
                item.code = code;
                item.last = closes && (i == COPIES - 1);
                expected_codes.push_back(item);
            end
        endfunction

        // Encode the finished run: symbol code, then the length for runs of three or more
        function void close_run();
            logic [7:0] code;
            bit         is_digit;
            is_digit = (open_sym > DIGIT_LO) && (open_sym < DIGIT_HI);
            if (open_len == 8'd1) begin
                code = is_digit ? open_sym - DIGIT_SINGLE : open_sym;
            end else begin
                code = is_digit ? open_sym - DIGIT_MULTI : open_sym + LETTER_MULTI;
            end
            if (open_len >= LEN_WITH_COPY) begin
                push_copies(code, 1'b0);
                push_copies(open_len, 1'b1);
            end else begin
                push_copies(code, 1'b1);
            end
        endfunction

        function void take_symbol(logic [7:0] sym);
            if (open_len == '0) begin
                // no open run: an end mark is dropped, anything else opens a run
                if (sym != END_MARK) begin
                    open_sym = sym;
                    open_len = 8'd1;
                end
            end else if (sym == open_sym) begin
                // extend the run, hold at the maximum length
                if (open_len != LEN_MAX)
                    open_len = open_len + 8'd1;
            end else begin
                close_run();
                open_sym = (sym == END_MARK) ? '0 : sym;
                open_len = (sym == END_MARK) ? '0 : 8'd1;
            end
        endfunction

        function void check_code(logic [7:0] code, logic last);
            code_item_t want;
            if (expected_codes.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected output: code=%0d last=%0b", $time, code, last);
                mismatches++;
                return;
            end
            want = expected_codes.pop_front();
            if (want.code !== code || want.last !== last) begin
                if (mismatches < 10)
                    $display("[%0t] mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
                             $time, want.code, want.last, code, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic [7:0] s_symbol_in   = '0;
    logic       m_ready       = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [7:0] m_code_byte;
    wire        m_last_of_run;

    run_code_checker board;
    bit              tx_steady = 1'b0;
    bit              rx_steady = 1'b0;
    int              cycles    = 0;

    triple_redundant_run_length_encoder_top #(
        .COPIES (COPIES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol_in   (s_symbol_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_byte   (m_code_byte),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Record input transfers and check output transfers at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.take_symbol(s_symbol_in);
            if (m_valid && m_ready)
                board.check_code(m_code_byte, m_last_of_run);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the output side for a random number of cycles before each transfer unless rx_steady is set
    initial begin
        int stall;
        int taken;
        taken = 0;
        forever begin
            if (taken % 32 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // Present one symbol after a random gap and hold it until the transfer
    task automatic send_symbol(input logic [7:0] sym);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_symbol_in <= sym;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_run(input logic [7:0] sym, input int count);
        for (int i = 0; i < count; i++)
            send_symbol(sym);
    endtask

    // Drop valid and hold off until every predicted byte has come out
    task automatic drain_outputs();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.expected_codes.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [7:0] sym;
        int         len;
        int         sent;
        bit         paused;
        board = new();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: end mark with nothing open, letters and digits at each length,
        // digit-range boundaries, wrap of the plus-32 code, repeated end marks
        send_symbol(END_MARK);
        send_run(8'h41, 1);
        send_run(8'h42, 2);
        send_run(8'h43, 3);
        send_run(8'h30, 1);
        send_run(8'h39, 2);
        send_run(8'h35, 4);
        send_run(8'h2F, 1);
        send_run(8'h3A, 1);
        send_run(8'hF0, 2);
        send_run(8'hFF, 1);
        send_symbol(END_MARK);
        send_symbol(END_MARK);
        send_run(8'h01, 3);
        send_symbol(END_MARK);
        drain_outputs();

        // Saturation: a run past the maximum length, then a run of exactly that length
        tx_steady = 1'b1;
        send_run(8'h7A, 260);
        send_run(8'h37, 255);
        send_symbol(END_MARK);
        tx_steady = 1'b0;
        drain_outputs();

        // Random runs, digit-heavy, with end marks mixed in
        sent   = 0;
        paused = 1'b0;
        while (sent < SOAK_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                tx_steady = !tx_steady;
            case ($urandom_range(0, 9))
                0:       sym = END_MARK;
                1, 2, 3: sym = 8'($urandom_range(48, 57));
                4:       sym = 8'($urandom_range(46, 59));
                default: sym = 8'($urandom_range(1, 255));
            endcase
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 12) : $urandom_range(1, 3);
            if (sym == END_MARK)
                len = $urandom_range(1, 2);
            send_run(sym, len);
            sent += len;
            if (!paused && sent >= SOAK_ITEMS / 2) begin
                drain_outputs();
                paused = 1'b1;
            end
        end
        send_symbol(END_MARK);
        drain_outputs();

        repeat (2 * COPIES + 20) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_codes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
